// ===== src/npid_pkg.sv =====
// Shared types and constants of the node pair id table.
package npid_pkg;

  localparam int NODE_W        = 31;
  localparam int COUNT_W       = 11;
  localparam int IDX_W         = 10;
  localparam int DEPTH_DEFAULT = 1024;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_BASE_NODE_COUNT = 2'd0;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_READ  = 2'd2,
    KIND_TAKE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_FOUND     = 3'd0,
    STS_INSERTED  = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_NO_NEW    = 3'd4,
    STS_BAD_INDEX = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_GRAB,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [IDX_W-1:0]   entry_index;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [NODE_W-1:0]   shell_node;
    logic [NODE_W-1:0]   low_node;
    logic [NODE_W-1:0]   high_node;
    logic [COUNT_W-1:0]  entry_count;
    logic [COUNT_W-1:0]  new_count;
  } out_item_t;

  // One table row as held in the RAM.
  typedef struct packed {
    logic [NODE_W-1:0] low;
    logic [NODE_W-1:0] high;
    logic [NODE_W-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/npid_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module npid_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/node_pair_id_table.sv =====
// Top level of the node pair id table: request sequencer, counters and config port.
//
// Table of unordered node-id pairs, each kept as (min, max) with an assigned id,
// all in one RAM of TABLE_DEPTH rows. Add and check scan the stored rows in order,
// one RAM read per cycle; the single RAM read port sets that rate. Read by index
// and take-new need one RAM read, through the fetch and grab states; a request
// answered from the counters alone (bad index, nothing new) goes straight to the
// done state. One request is in work at a time; a finished result waits in the
// output register, and the next request transfers only once the previous result
// has moved into the output register. Add appends a missed pair with id =
// base_node_count + entries (after the append, modulo 2^31) and reports table full
// at TABLE_DEPTH entries.
// base_node_count sits at byte address 0 of the config port; write it only while
// no request is in work. Table rows need no clearing after reset: a row is read
// only below the stored entry count.
module node_pair_id_table #(
  parameter int TABLE_DEPTH = npid_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  npid_pkg::in_item_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output npid_pkg::out_item_t           out_data,
  // config port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [npid_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [npid_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [npid_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  // Row address, count and widened compare widths.
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int IXW = (CW > npid_pkg::IDX_W) ? CW : npid_pkg::IDX_W;
  localparam int CXW = (CW > npid_pkg::COUNT_W) ? CW : npid_pkg::COUNT_W;

  localparam int NW = npid_pkg::NODE_W;

  // ---------------------------------------------------------------- state
  npid_pkg::state_t    state_r, state_nxt;
  npid_pkg::kind_t     kind_r, kind_nxt;
  logic [NW-1:0]       lo_r, lo_nxt;
  logic [NW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic                cmp_last_r, cmp_last_nxt;
  npid_pkg::out_item_t res_r, res_nxt;
  logic [CW-1:0]       stored_r, stored_nxt;
  logic [CW-1:0]       untaken_r, untaken_nxt;
  logic [NW-1:0]       base_r, base_nxt;
  logic                out_valid_r, out_valid_nxt;
  npid_pkg::out_item_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- RAM
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  npid_pkg::entry_t        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  npid_pkg::entry_t        ram_rdata;

  npid_ram #(
    .WIDTH (npid_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- helpers
  logic            in_xfer;
  logic [NW-1:0]   in_lo, in_hi;
  logic [IXW-1:0]  idx_ext, stored_ext;
  logic [CW-1:0]   take_pos;
  logic            row_match, scan_hit, scan_miss, scan_issue;
  logic [CXW-1:0]  stored_cnt_ext, untaken_cnt_ext;
  logic            cfg_wr;

  assign in_ready = (state_r == npid_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Order the pair as (min, max).
  assign in_lo = (in_data.node_a < in_data.node_b) ? in_data.node_a : in_data.node_b;
  assign in_hi = (in_data.node_a < in_data.node_b) ? in_data.node_b : in_data.node_a;

  assign idx_ext    = IXW'(in_data.entry_index);
  assign stored_ext = IXW'(stored_r);
  assign take_pos   = stored_r - untaken_r;

  // Compare stage of the scan: data of the row issued in the previous cycle.
  assign row_match  = (ram_rdata.low == lo_r) && (ram_rdata.high == hi_r);
  assign scan_hit   = (state_r == npid_pkg::S_SCAN) && cmp_v_r && row_match;
  // Miss once the last stored row failed, or at once on an empty table.
  assign scan_miss  = (state_r == npid_pkg::S_SCAN) &&
                      ((cmp_v_r && cmp_last_r && !row_match) || (stored_r == '0));
  assign scan_issue = (scan_r < stored_r) && !scan_hit;

  // Result counts show the low count bits after the request.
  assign stored_cnt_ext  = CXW'(stored_nxt);
  assign untaken_cnt_ext = CXW'(untaken_nxt);

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npid_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_data.kind)
            npid_pkg::KIND_ADD, npid_pkg::KIND_CHECK: state_nxt = npid_pkg::S_SCAN;
            npid_pkg::KIND_READ: begin
              state_nxt = (idx_ext < stored_ext) ? npid_pkg::S_FETCH : npid_pkg::S_DONE;
            end
            npid_pkg::KIND_TAKE: begin
              state_nxt = (untaken_r == '0 || untaken_r > stored_r) ?
                          npid_pkg::S_DONE : npid_pkg::S_FETCH;
            end
            default: state_nxt = npid_pkg::S_IDLE;
          endcase
        end
      end
      npid_pkg::S_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_nxt = npid_pkg::S_DONE;
        end
      end
      npid_pkg::S_FETCH: state_nxt = npid_pkg::S_GRAB;
      npid_pkg::S_GRAB:  state_nxt = npid_pkg::S_DONE;
      npid_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = npid_pkg::S_IDLE;
        end
      end
      default: state_nxt = npid_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    kind_nxt      = kind_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    addr_nxt      = addr_r;
    scan_nxt      = scan_r;
    cmp_v_nxt     = 1'b0;
    cmp_last_nxt  = cmp_last_r;
    res_nxt       = res_r;
    stored_nxt    = stored_r;
    untaken_nxt   = untaken_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = stored_r[AW-1:0];
    ram_wdata     = '{low: lo_r, high: hi_r, id: base_r + NW'(stored_r + CW'(1))};
    ram_raddr     = (state_r == npid_pkg::S_SCAN) ? scan_r[AW-1:0] : addr_r;

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr && cfg_paddr == npid_pkg::ADDR_BASE_NODE_COUNT) begin
      base_nxt = cfg_pwdata[NW-1:0];
    end

    case (state_r)
      npid_pkg::S_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_data.kind;
          lo_nxt   = in_lo;
          hi_nxt   = in_hi;
          scan_nxt = '0;
          case (in_data.kind)
            npid_pkg::KIND_READ: begin
              addr_nxt = idx_ext[AW-1:0];
              res_nxt  = '{status: npid_pkg::STS_BAD_INDEX, shell_node: '0, low_node: '0,
                           high_node: '0, entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                           new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
            end
            npid_pkg::KIND_TAKE: begin
              addr_nxt = take_pos[AW-1:0];
              if (untaken_r == '0 || untaken_r > stored_r) begin
                res_nxt = '{status: npid_pkg::STS_NO_NEW, shell_node: '0, low_node: '0,
                            high_node: '0,
                            entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                            new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
              end else begin
                untaken_nxt = untaken_r - CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      npid_pkg::S_SCAN: begin
        // Issue one row per cycle; the compare follows in the next cycle.
        if (scan_issue) begin
          scan_nxt     = scan_r + CW'(1);
          cmp_v_nxt    = 1'b1;
          cmp_last_nxt = (scan_r == stored_r - CW'(1));
        end
        if (scan_hit) begin
          res_nxt = '{status: npid_pkg::STS_FOUND, shell_node: ram_rdata.id, low_node: lo_r,
                      high_node: hi_r, entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                      new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
        end else if (scan_miss) begin
          if (kind_r == npid_pkg::KIND_CHECK) begin
            res_nxt = '{status: npid_pkg::STS_NOT_FOUND, shell_node: '0, low_node: lo_r,
                        high_node: hi_r, entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                        new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
          end else if (stored_r >= CW'(TABLE_DEPTH)) begin
            res_nxt = '{status: npid_pkg::STS_FULL, shell_node: '0, low_node: lo_r,
                        high_node: hi_r, entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                        new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
          end else begin
            // Append the pair at the end of the table.
            ram_we      = 1'b1;
            stored_nxt  = stored_r + CW'(1);
            untaken_nxt = untaken_r + CW'(1);
            res_nxt = '{status: npid_pkg::STS_INSERTED, shell_node: ram_wdata.id,
                        low_node: lo_r, high_node: hi_r,
                        entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                        new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
          end
        end
      end
      npid_pkg::S_GRAB: begin
        res_nxt = '{status: npid_pkg::STS_FOUND, shell_node: ram_rdata.id,
                    low_node: ram_rdata.low, high_node: ram_rdata.high,
                    entry_count: stored_cnt_ext[npid_pkg::COUNT_W-1:0],
                    new_count: untaken_cnt_ext[npid_pkg::COUNT_W-1:0]};
      end
      npid_pkg::S_DONE: begin
        // Advance the result into the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npid_pkg::S_IDLE;
      cmp_v_r     <= 1'b0;
      stored_r    <= '0;
      untaken_r   <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      stored_r    <= stored_nxt;
      untaken_r   <= untaken_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    addr_r     <= addr_nxt;
    scan_r     <= scan_nxt;
    cmp_last_r <= cmp_last_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == npid_pkg::ADDR_BASE_NODE_COUNT) ?
                      {1'b0, base_r} : '0;

  // ---------------------------------------------------------------- assertions
  a_new_within_stored: assert property (@(posedge clk) disable iff (!rst_n)
    untaken_r <= stored_r)
    else $error("untaken new entries exceed stored entries");

  a_stored_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CW'(TABLE_DEPTH))
    else $error("stored entry count beyond table depth");

  a_append_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (stored_r < CW'(TABLE_DEPTH)) && (state_r == npid_pkg::S_SCAN))
    else $error("row written with no room or outside a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == npid_pkg::S_DONE))
    else $error("result presented without a finished request");

endmodule
